/* sv/grid_diffusion_decay_step_defines.svh */
// assertion macros for the grid diffusion and decay block
// used by the port checker only, no other dependencies
`ifndef GRID_DIFFUSION_DECAY_STEP_DEFINES_SVH
`define GRID_DIFFUSION_DECAY_STEP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GDDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define GDDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gdds_pkg.sv */
// shared constants, command codes and control structs of the grid block
// no dependencies
package gdds_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int CELL_W   = 24;
    localparam int CHG_W    = 32;
    localparam int CFG_W    = 16;
    localparam int SIZE_W   = 7;
    localparam int OP_W     = 3;
    localparam int CIDX_W   = 3;
    localparam int K_W      = 4;

    localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;
    localparam logic [OP_W-1:0] OP_STEP  = 3'd5;

    localparam logic [CIDX_W-1:0] CFG_KDIFF = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_KDEG  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DT    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_ROWS  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_COLS  = 3'd4;

    localparam logic [K_W-1:0] K_LAST = 4'd8;

    typedef struct packed {
        logic cap;        // latch the accepted item
        logic swp_wr;     // zero one cell of the sweep
        logic rd_item;    // read the addressed cell
        logic mod_wr;     // write back write/add/subtract
        logic step_init;  // first interior cell, stencil point zero
        logic p1_rd;      // read one stencil point
        logic p1_wr;      // store the change of one cell
        logic p2_rd;      // read cell and its change
        logic p2_wr;      // store the updated cell
        logic out_en;     // present the result
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            swp_last;
        logic            k_last;
        logic            cell_last;
        logic            interior;
    } t_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
    endfunction

endpackage

/* sv/grid_diffusion_decay_step.sv */
// top level of the grid diffusion and decay block
// depends on gdds_pkg, gdds_ctrl and gdds_dp
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------------------
// command   | in        | start, busy               | i_opcode, i_row_index,
//           |           |                           | i_col_index, i_amount
// result    | out       | o_result_strobe (1 cycle) | o_read_value, o_index_valid
// config    | in        | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// write, add, subtract, read: accept, decode with the cell read, write-back, registered strobe
// clear: the sweep zeroes every cell of the cell memory, one cell per cycle
// step: a change pass over the interior cells (nine stencil reads per cell through
//   the single cell memory read port), then an update pass over the same cells
// after reset a clearing pass over all DEPTH (4096) cells runs with busy high;
//   config writes are taken at any time, ready is always high
// the receiver cannot stall: each result shows for exactly one cycle
module grid_diffusion_decay_step import gdds_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command items
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [SIZE_W-1:0]   i_row_index,
    input  logic [SIZE_W-1:0]   i_col_index,
    input  logic [CELL_W-1:0]   i_amount,
    // result items
    output logic                o_result_strobe,
    output logic [CELL_W-1:0]   o_read_value,
    output logic                o_index_valid,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    // register file never holds off a write
    assign o_cfg_ready = 1'b1;
    assign busy        = ctrl_busy;

    // sequencer: reset and clear sweep, decode, item write-back, stencil pass, update pass
    gdds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    // memories, arithmetic and result register
    gdds_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_amount        (i_amount),
        .o_result_strobe (o_result_strobe),
        .o_read_value    (o_read_value),
        .o_index_valid   (o_index_valid)
    );

endmodule

/* sv/gdds_ctrl.sv */
// command sequencer of the grid block: sweep, item commands, two-pass step
// depends on gdds_pkg
module gdds_ctrl import gdds_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_DEC, S_MOD,
        S_P1_RD, S_P1_LAST, S_P1_MUL, S_P1_WR,
        S_P2_RD, S_P2_MUL, S_P2_WR
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_clr, n_clr;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        o_cmd   = '0;
        case (r_state)
            S_SWEEP: begin
                o_cmd.swp_wr = 1'b1;
                if (i_stat.swp_last) begin
                    o_cmd.out_en = r_clr;
                    n_state      = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                n_clr = (i_stat.op == OP_CLEAR);
                case (i_stat.op)
                    OP_WRITE, OP_ADD, OP_SUB, OP_READ: begin
                        o_cmd.rd_item = 1'b1;
                        n_state       = S_MOD;
                    end
                    OP_CLEAR: n_state = S_SWEEP;
                    OP_STEP: begin
                        o_cmd.step_init = 1'b1;
                        if (i_stat.interior) begin
                            n_state = S_P1_RD;
                        end else begin
                            o_cmd.out_en = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.out_en = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_MOD: begin
                o_cmd.mod_wr = 1'b1;
                o_cmd.out_en = 1'b1;
                n_state      = S_IDLE;
            end
            S_P1_RD: begin
                o_cmd.p1_rd = 1'b1;
                if (i_stat.k_last) n_state = S_P1_LAST;
            end
            S_P1_LAST: n_state = S_P1_MUL;
            S_P1_MUL:  n_state = S_P1_WR;
            S_P1_WR: begin
                o_cmd.p1_wr = 1'b1;
                if (i_stat.cell_last) begin
                    o_cmd.step_init = 1'b1;
                    n_state         = S_P2_RD;
                end else begin
                    n_state = S_P1_RD;
                end
            end
            S_P2_RD: begin
                o_cmd.p2_rd = 1'b1;
                n_state     = S_P2_MUL;
            end
            S_P2_MUL: n_state = S_P2_WR;
            S_P2_WR: begin
                o_cmd.p2_wr = 1'b1;
                if (i_stat.cell_last) begin
                    o_cmd.out_en = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_P2_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_busy  <= 1'b1;
            r_clr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_clr   <= n_clr;
        end
    end

    assign o_busy = r_busy;

endmodule

/* sv/gdds_dp.sv */
// datapath of the grid block: config registers, cell and change memories,
// stencil accumulator, multipliers and result register; depends on gdds_pkg
module gdds_dp import gdds_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [SIZE_W-1:0]   i_row_index,
    input  logic [SIZE_W-1:0]   i_col_index,
    input  logic [CELL_W-1:0]   i_amount,
    output logic                o_result_strobe,
    output logic [CELL_W-1:0]   o_read_value,
    output logic                o_index_valid
);

    localparam int ACC_W  = 30;
    localparam int PD_W   = ACC_W + CFG_W + 1;
    localparam int PG_W   = CFG_W + CELL_W;
    localparam int FULL_W = PD_W + 1;
    localparam int PT_W   = CHG_W + CFG_W + 1;
    localparam int NV_W   = PT_W + 1;

    // configuration
    logic [CFG_W-1:0]  r_kdiff, r_kdeg, r_dt;
    logic [SIZE_W-1:0] r_rows, r_cols;
    logic [SIZE_W-1:0] rows_eff, cols_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kdiff <= '0;
            r_kdeg  <= '0;
            r_dt    <= '0;
            r_rows  <= SIZE_RST;
            r_cols  <= SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KDIFF: r_kdiff <= i_cfg_data;
                CFG_KDEG:  r_kdeg  <= i_cfg_data;
                CFG_DT:    r_dt    <= i_cfg_data;
                CFG_ROWS:  r_rows  <= i_cfg_data[SIZE_W-1:0];
                CFG_COLS:  r_cols  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign rows_eff = (int'(r_rows) < MAX_ROWS) ? r_rows : SIZE_W'(MAX_ROWS);
    assign cols_eff = (int'(r_cols) < MAX_COLS) ? r_cols : SIZE_W'(MAX_COLS);

    // item capture and range tests
    logic [OP_W-1:0]   r_op;
    logic              r_ok;
    logic [CELL_W-1:0] r_amt;
    logic [ADDR_W-1:0] r_item_addr;
    logic              full_ok, add_ok, n_ok;

    always_comb begin
        full_ok = (i_row_index < rows_eff) && (i_col_index < cols_eff);
        add_ok  = (i_row_index >= 7'd2) && (i_col_index >= 7'd2)
               && (({1'b0, i_row_index} + 8'd1) < {1'b0, rows_eff})
               && (({1'b0, i_col_index} + 8'd1) < {1'b0, cols_eff});
        case (i_opcode)
            OP_WRITE, OP_SUB, OP_READ: n_ok = full_ok;
            OP_ADD:                    n_ok = add_ok;
            default:                   n_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op        <= i_opcode;
            r_ok        <= n_ok;
            r_amt       <= i_amount;
            r_item_addr <= cell_addr(ROW_W'(i_row_index), COL_W'(i_col_index));
        end
    end

    // sweep counter and step walk
    logic [ADDR_W-1:0] r_swp;
    logic [ROW_W-1:0]  r_r, rr;
    logic [COL_W-1:0]  r_c, cc;
    logic [K_W-1:0]    r_k;
    logic              swp_last, row_end, cell_last;

    assign swp_last  = (r_swp == ADDR_W'(DEPTH - 1));
    assign row_end   = (int'(r_c) == int'(cols_eff) - 2);
    assign cell_last = row_end && (int'(r_r) == int'(rows_eff) - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp <= '0;
        end else if (i_cmd.swp_wr) begin
            r_swp <= swp_last ? '0 : r_swp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_init) begin
            r_r <= ROW_W'(1);
            r_c <= COL_W'(1);
            r_k <= '0;
        end else begin
            if (i_cmd.p1_rd) r_k <= (r_k == K_LAST) ? '0 : r_k + 1'b1;
            if (i_cmd.p1_wr || i_cmd.p2_wr) begin
                if (row_end) begin
                    r_c <= COL_W'(1);
                    r_r <= r_r + 1'b1;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
        end
    end

    // stencil point k, row-major over the 3x3 window
    always_comb begin
        case (r_k)
            4'd0:    begin rr = r_r - 1'b1; cc = r_c - 1'b1; end
            4'd1:    begin rr = r_r - 1'b1; cc = r_c;        end
            4'd2:    begin rr = r_r - 1'b1; cc = r_c + 1'b1; end
            4'd3:    begin rr = r_r;        cc = r_c - 1'b1; end
            4'd5:    begin rr = r_r;        cc = r_c + 1'b1; end
            4'd6:    begin rr = r_r + 1'b1; cc = r_c - 1'b1; end
            4'd7:    begin rr = r_r + 1'b1; cc = r_c;        end
            4'd8:    begin rr = r_r + 1'b1; cc = r_c + 1'b1; end
            default: begin rr = r_r;        cc = r_c;        end
        endcase
    end

    // memories
    logic [CELL_W-1:0] cell_mem [DEPTH];
    logic [CHG_W-1:0]  chg_mem  [DEPTH];
    logic [CELL_W-1:0] r_cell_q;
    logic [CHG_W-1:0]  r_chg_q;
    logic [ADDR_W-1:0] step_addr, cell_raddr, cell_waddr;
    logic [CELL_W-1:0] cell_wdata, mod_val, upd_val;
    logic              cell_re, cell_we, mod_we;
    logic [CELL_W:0]   add_sum;
    logic [CHG_W-1:0]  chg_wdata;

    assign step_addr = cell_addr(r_r, r_c);
    assign cell_re   = i_cmd.rd_item | i_cmd.p1_rd | i_cmd.p2_rd;
    assign mod_we    = i_cmd.mod_wr && r_ok
                    && ((r_op == OP_WRITE) || (r_op == OP_ADD) || (r_op == OP_SUB));
    assign cell_we   = i_cmd.swp_wr | mod_we | i_cmd.p2_wr;

    always_comb begin
        if (i_cmd.p1_rd)      cell_raddr = cell_addr(rr, cc);
        else if (i_cmd.p2_rd) cell_raddr = step_addr;
        else                  cell_raddr = r_item_addr;
    end

    always_comb begin
        add_sum = {1'b0, r_cell_q} + {1'b0, r_amt};
        case (r_op)
            OP_ADD:  mod_val = add_sum[CELL_W] ? CELL_MAX : add_sum[CELL_W-1:0];
            OP_SUB:  mod_val = (r_cell_q > r_amt) ? r_cell_q - r_amt : '0;
            default: mod_val = r_amt;
        endcase
    end

    always_comb begin
        if (i_cmd.swp_wr) begin
            cell_waddr = r_swp;
            cell_wdata = '0;
        end else if (i_cmd.p2_wr) begin
            cell_waddr = step_addr;
            cell_wdata = upd_val;
        end else begin
            cell_waddr = r_item_addr;
            cell_wdata = mod_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
        if (cell_re) r_cell_q <= cell_mem[cell_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.p1_wr) chg_mem[step_addr] <= chg_wdata;
        if (i_cmd.p2_rd) r_chg_q <= chg_mem[step_addr];
    end

    // stencil sum in half units
    logic                    r_acc_vld;
    logic [K_W-1:0]          r_acc_k;
    logic signed [ACC_W-1:0] r_acc, acc_v, acc_term;
    logic [CELL_W-1:0]       r_ctr;

    always_comb begin
        acc_v = signed'(ACC_W'(r_cell_q));
        case (r_acc_k)
            4'd1, 4'd3, 4'd5, 4'd7: acc_term = acc_v <<< 1;
            4'd4:                   acc_term = -(acc_v <<< 3) - (acc_v <<< 2);
            default:                acc_term = acc_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.p1_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_k <= r_k;
        if (i_cmd.p1_rd && (r_k == '0)) r_acc <= '0;
        else if (r_acc_vld)             r_acc <= r_acc + acc_term;
        if (r_acc_vld && (r_acc_k == 4'd4)) r_ctr <= r_cell_q;
    end

    // change and update arithmetic, one register after each multiply
    logic signed [PD_W-1:0]   r_pdiff;
    logic [PG_W-1:0]          r_pdeg;
    logic signed [FULL_W-1:0] full, full_sh;
    logic signed [PT_W-1:0]   r_pdt, inc;
    logic signed [NV_W-1:0]   nv;

    always_ff @(posedge i_clk) begin
        r_pdiff <= $signed({1'b0, r_kdiff}) * r_acc;
        r_pdeg  <= r_kdeg * r_ctr;
        r_pdt   <= $signed({1'b0, r_dt}) * $signed(r_chg_q);
    end

    always_comb begin
        full      = FULL_W'(r_pdiff) - signed'(FULL_W'({r_pdeg, 1'b0}));
        full_sh   = full >>> 17;
        chg_wdata = full_sh[CHG_W-1:0];
        inc       = r_pdt >>> 16;
        nv        = signed'(NV_W'(r_cell_q)) + NV_W'(inc);
        if (nv < 0)                                upd_val = '0;
        else if (nv > signed'(NV_W'(CELL_MAX)))    upd_val = CELL_MAX;
        else                                       upd_val = nv[CELL_W-1:0];
    end

    // result register
    logic              r_strobe, r_iv;
    logic [CELL_W-1:0] r_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.out_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_iv <= r_ok;
            r_rv <= ((r_op == OP_READ) && r_ok) ? r_cell_q : '0;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_read_value    = r_rv;
    assign o_index_valid   = r_iv;

    assign o_stat.op        = r_op;
    assign o_stat.swp_last  = swp_last;
    assign o_stat.k_last    = (r_k == K_LAST);
    assign o_stat.cell_last = cell_last;
    assign o_stat.interior  = (rows_eff >= 7'd3) && (cols_eff >= 7'd3);

endmodule

/* sv/gdds_chk.sv */
// port checker for the grid block, bound to the top level
// depends on gdds_pkg and the assertion macro header
`include "grid_diffusion_decay_step_defines.svh"

module gdds_chk import gdds_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_result_strobe,
    input logic [CELL_W-1:0]   o_read_value,
    input logic                o_index_valid
);

    `GDDS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy low after accept")
    `GDDS_ASSERT_IMP(a_strobe_after_busy, i_clk, i_rst_n, o_result_strobe, $past(busy), "result with no item in work")
    `GDDS_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_result_strobe, !o_result_strobe, "result repeated")
    `GDDS_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, o_result_strobe && !o_index_valid, o_read_value == '0, "value without valid index")

endmodule

bind grid_diffusion_decay_step gdds_chk u_gdds_chk (.*);
